[hw/rtl/jve_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jve_pkg - shared types and constants of the joint velocity estimator
// widths, register indexes, reset values, sequencer states and the
// control / status bundles between the sequencer and its arithmetic units
// ----------------------------------------------------------------------------
package jve_pkg;

    localparam int JOINTS = 3;
    localparam int J_W    = $clog2(JOINTS);

    localparam int ANG_W  = 24;   // raw motor angle
    localparam int JANG_W = 25;   // joint angle
    localparam int DIFF_W = 26;   // angle change
    localparam int RATE_W = 23;   // velocity
    localparam int TQ_W   = 24;   // torque
    localparam int DT_W   = 20;   // interval in us
    localparam int ALPHA_W = 16;
    localparam int VLIM_W = 22;

    // iterative divider: dividend is |delta| * 1e6, quotient kept to Q_W bits
    localparam int DIVN_W = 46;
    localparam int Q_W    = 23;
    localparam int CNT_W  = $clog2(Q_W + 1);

    // shared multiply-accumulate unit
    localparam int MAC_A_W = 27;
    localparam int MAC_B_W = 24;
    localparam int MAC_P_W = MAC_A_W + MAC_B_W;

    localparam logic signed [MAC_B_W-1:0] USEC_PER_SEC = 24'sd1000000;
    localparam logic [ALPHA_W:0]          ALPHA_ONE    = 17'h10000;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL_US = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL_US = 3'd4;
    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic signed [ANG_W-1:0] RST_ANGLE_OFFSET  = -24'sd68616;
    localparam logic [ALPHA_W-1:0]      RST_ALPHA_WEIGHT  = 16'd26214;
    localparam logic [VLIM_W-1:0]       RST_VELOCITY_LIMIT = 22'd2949120;
    localparam logic [DT_W-1:0]         RST_MIN_INTERVAL  = 20'd500;
    localparam logic [DT_W-1:0]         RST_MAX_INTERVAL  = 20'd50000;

    localparam logic signed [TQ_W-1:0] TQ_MOST_NEG = {1'b1, {(TQ_W-1){1'b0}}};
    localparam logic signed [TQ_W-1:0] TQ_MOST_POS = {1'b0, {(TQ_W-1){1'b1}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_MUL_D,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SAT,
        ST_MUL_A,
        ST_MUL_B,
        ST_STORE,
        ST_FINISH
    } st_t;

    typedef struct packed {
        logic en;
        logic clear;
    } mac_ctl_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

endpackage

[hw/rtl/joint_velocity_ewma_estimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_velocity_ewma_estimator - joint angle, torque and filtered velocity
// converts three motor angles and torques to joint convention and tracks an
// exponentially weighted average of each joint's velocity
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one item of three raw angles, three raw torques and the
//   microseconds since the previous item, taken when s_valid and s_ready
//   m_* channel: one result item per input item, held until m_ready
//   cfg_* channel: register writes, always ready; write only while idle
// sequencing
//   first item after reset: it only seeds the previous angles; the
//   finish state loads its result once the output register is free
//   later items: per joint, the shared divider takes one quotient bit
//   per cycle until done; a division whose quotient overflows finishes
//   at once and shortens that joint's pass
//   s_ready is high only while the sequencer is idle, so one item is in
//   work at a time; no new item is taken before the last result is loaded
// reset
//   aresetn (synchronous, active low) restores register defaults, drops
//   m_valid and marks the estimator unprimed
// stall
//   a finished result waits in the output register; the next item is still
//   taken, and its result waits in the sequencer until the slot frees up
// ----------------------------------------------------------------------------
module joint_velocity_ewma_estimator
    import jve_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    // input items
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [ANG_W-1:0]   s_angle_a,
    input  logic signed [ANG_W-1:0]   s_angle_b,
    input  logic signed [ANG_W-1:0]   s_angle_c,
    input  logic signed [TQ_W-1:0]    s_torque_a,
    input  logic signed [TQ_W-1:0]    s_torque_b,
    input  logic signed [TQ_W-1:0]    s_torque_c,
    input  logic [DT_W-1:0]           s_elapsed_us,

    // result items
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [JANG_W-1:0]  m_joint_angle_a,
    output logic signed [JANG_W-1:0]  m_joint_angle_b,
    output logic signed [JANG_W-1:0]  m_joint_angle_c,
    output logic signed [RATE_W-1:0]  m_joint_rate_a,
    output logic signed [RATE_W-1:0]  m_joint_rate_b,
    output logic signed [RATE_W-1:0]  m_joint_rate_c,
    output logic signed [TQ_W-1:0]    m_joint_torque_a,
    output logic signed [TQ_W-1:0]    m_joint_torque_b,
    output logic signed [TQ_W-1:0]    m_joint_torque_c
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0] offset_reg;
    logic [ALPHA_W-1:0]      alpha_reg;
    logic [VLIM_W-1:0]       vlim_reg;
    logic [DT_W-1:0]         min_dt_reg;
    logic [DT_W-1:0]         max_dt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= RST_ANGLE_OFFSET;
            alpha_reg  <= RST_ALPHA_WEIGHT;
            vlim_reg   <= RST_VELOCITY_LIMIT;
            min_dt_reg <= RST_MIN_INTERVAL;
            max_dt_reg <= RST_MAX_INTERVAL;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ANGLE_OFFSET:    offset_reg <= cfg_data[ANG_W-1:0];
                CFG_ALPHA_WEIGHT:    alpha_reg  <= cfg_data[ALPHA_W-1:0];
                CFG_VELOCITY_LIMIT:  vlim_reg   <= cfg_data[VLIM_W-1:0];
                CFG_MIN_INTERVAL_US: min_dt_reg <= cfg_data[DT_W-1:0];
                CFG_MAX_INTERVAL_US: max_dt_reg <= cfg_data[DT_W-1:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // front end: joint convention and interval clamp, done at acceptance
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0]  raw_ang [JOINTS];
    logic signed [TQ_W-1:0]   raw_tq  [JOINTS];
    logic signed [JANG_W-1:0] ang_in  [JOINTS];
    logic signed [TQ_W-1:0]   tq_in   [JOINTS];
    logic [DT_W-1:0]          dt_lo;
    logic [DT_W-1:0]          dt_hi;
    logic [DT_W-1:0]          dt_in;

    assign raw_ang[0] = s_angle_a;
    assign raw_ang[1] = s_angle_b;
    assign raw_ang[2] = s_angle_c;
    assign raw_tq[0]  = s_torque_a;
    assign raw_tq[1]  = s_torque_b;
    assign raw_tq[2]  = s_torque_c;

    always_comb begin
        for (int i = 0; i < JOINTS; i++) begin
            ang_in[i] = {offset_reg[ANG_W-1], offset_reg}
                      - {raw_ang[i][ANG_W-1], raw_ang[i]};
            // negating the most negative torque saturates
            tq_in[i] = (raw_tq[i] == TQ_MOST_NEG) ? TQ_MOST_POS : -raw_tq[i];
        end
    end

    // raise to min first, then lower to max; a zero interval becomes 1 us
    assign dt_lo = (s_elapsed_us < min_dt_reg) ? min_dt_reg : s_elapsed_us;
    assign dt_hi = (dt_lo > max_dt_reg) ? max_dt_reg : dt_lo;
    assign dt_in = (dt_hi == '0) ? DT_W'(1) : dt_hi;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    st_t             st_reg, st_next;
    logic [J_W-1:0]  j_reg;
    logic            primed_reg;
    logic            last_joint;
    logic            accept;
    logic            out_free;
    logic            out_load;
    logic            div_start;
    mac_ctl_t        mac_ctl;
    div_stat_t       div_stat;

    assign accept     = s_valid && s_ready;
    assign last_joint = (j_reg == J_W'(JOINTS - 1));
    assign out_free   = !m_valid || m_ready;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // the first item only seeds the previous angles
                    st_next = primed_reg ? ST_DELTA : ST_FINISH;
                end
            end
            ST_DELTA:     st_next = ST_MUL_D;
            ST_MUL_D:     st_next = ST_DIV_START;
            ST_DIV_START: st_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    st_next = ST_SAT;
                end
            end
            ST_SAT:   st_next = ST_MUL_A;
            ST_MUL_A: st_next = ST_MUL_B;
            ST_MUL_B: st_next = ST_STORE;
            ST_STORE: st_next = last_joint ? ST_FINISH : ST_DELTA;
            ST_FINISH: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        mac_ctl.en    = 1'b0;
        mac_ctl.clear = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (st_reg)
            ST_IDLE:      s_ready = 1'b1;
            ST_MUL_D: begin
                mac_ctl.en    = 1'b1;
                mac_ctl.clear = 1'b1;
            end
            ST_DIV_START: div_start = 1'b1;
            ST_MUL_A: begin
                mac_ctl.en    = 1'b1;
                mac_ctl.clear = 1'b1;
            end
            ST_MUL_B:     mac_ctl.en = 1'b1;
            ST_FINISH:    out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            primed_reg <= 1'b0;
            j_reg      <= '0;
        end else begin
            st_reg <= st_next;
            if (accept) begin
                primed_reg <= 1'b1;
                j_reg      <= '0;
            end else if (st_reg == ST_STORE) begin
                // wrap after the last joint so the index stays in range
                j_reg <= last_joint ? '0 : j_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // per joint datapath
    // ------------------------------------------------------------------
    logic signed [JANG_W-1:0] ang_reg  [JOINTS];
    logic signed [JANG_W-1:0] prev_reg [JOINTS];
    logic signed [RATE_W-1:0] avg_reg  [JOINTS];
    logic signed [TQ_W-1:0]   tq_reg   [JOINTS];
    logic [DT_W-1:0]          dt_reg;
    logic [DIFF_W-1:0]        dabs_reg;
    logic                     neg_reg;
    logic signed [RATE_W-1:0] raw_reg;

    logic signed [DIFF_W-1:0] delta;
    logic [Q_W-1:0]           quotient;
    logic [VLIM_W-1:0]        mag;
    logic signed [RATE_W-1:0] raw_next;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic signed [MAC_P_W-1:0] acc;

    assign delta = {ang_reg[j_reg][JANG_W-1], ang_reg[j_reg]}
                 - {prev_reg[j_reg][JANG_W-1], prev_reg[j_reg]};

    // saturate the magnitude, then put the sign back
    assign mag = (div_stat.ovf || (quotient > Q_W'(vlim_reg)))
               ? vlim_reg : quotient[VLIM_W-1:0];
    assign raw_next = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    // operand select for the shared multiplier
    always_comb begin
        case (st_reg)
            ST_MUL_D: begin
                mac_a = $signed({1'b0, dabs_reg});
                mac_b = USEC_PER_SEC;
            end
            ST_MUL_A: begin
                mac_a = $signed(MAC_A_W'(alpha_reg));
                mac_b = MAC_B_W'(avg_reg[j_reg]);
            end
            ST_MUL_B: begin
                mac_a = $signed(MAC_A_W'(ALPHA_ONE - {1'b0, alpha_reg}));
                mac_b = MAC_B_W'(raw_reg);
            end
            default: begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dt_reg <= dt_in;
            for (int i = 0; i < JOINTS; i++) begin
                ang_reg[i] <= ang_in[i];
                tq_reg[i]  <= tq_in[i];
                if (!primed_reg) begin
                    prev_reg[i] <= ang_in[i];
                    avg_reg[i]  <= '0;
                end
            end
        end
        if (st_reg == ST_DELTA) begin
            neg_reg  <= delta[DIFF_W-1];
            dabs_reg <= delta[DIFF_W-1] ? -delta : delta;
        end
        if (st_reg == ST_SAT) begin
            raw_reg <= raw_next;
        end
        if (st_reg == ST_STORE) begin
            // arithmetic shift by 16 of the blended sum
            avg_reg[j_reg]  <= acc[RATE_W+15:16];
            prev_reg[j_reg] <= ang_reg[j_reg];
        end
    end

    jve_mac u_mac (
        .aclk  (aclk),
        .ctl   (mac_ctl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (acc)
    );

    jve_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc[DIVN_W-1:0]),
        .divisor  (dt_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic m_valid_reg, m_valid_next;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_joint_angle_a  <= ang_reg[0];
            m_joint_angle_b  <= ang_reg[1];
            m_joint_angle_c  <= ang_reg[2];
            m_joint_rate_a   <= avg_reg[0];
            m_joint_rate_b   <= avg_reg[1];
            m_joint_rate_c   <= avg_reg[2];
            m_joint_torque_a <= tq_reg[0];
            m_joint_torque_b <= tq_reg[1];
            m_joint_torque_c <= tq_reg[2];
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[hw/rtl/jve_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jve_mac - shared multiply-accumulate unit
// one signed product per cycle while ctl.en is high, added to the accumulator or loaded fresh
// ----------------------------------------------------------------------------
module jve_mac
    import jve_pkg::*;
(
    input  logic                        aclk,
    input  mac_ctl_t                    ctl,
    input  logic signed [MAC_A_W-1:0]   op_a,
    input  logic signed [MAC_B_W-1:0]   op_b,
    output logic signed [MAC_P_W-1:0]   acc
);

    logic signed [MAC_P_W-1:0] acc_reg;
    logic signed [MAC_P_W-1:0] acc_next;
    logic signed [MAC_P_W-1:0] prod;

    assign prod = op_a * op_b;

    always_comb begin
        acc_next = acc_reg;
        if (ctl.en) begin
            acc_next = (ctl.clear ? '0 : acc_reg) + prod;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[hw/rtl/jve_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jve_div - iterative restoring divider
// one quotient bit per cycle; flags overflow when the quotient needs more
// than Q_W bits
// ----------------------------------------------------------------------------
module jve_div
    import jve_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [DT_W-1:0]   divisor,
    output div_stat_t         stat,
    output logic [Q_W-1:0]    quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DT_W-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0]   low_reg, low_next;
    logic [Q_W-1:0]   quo_reg, quo_next;

    logic [Q_W-1:0]   top_part;
    logic [DT_W:0]    trial;
    logic [DT_W:0]    diff;

    assign top_part = dividend[DIVN_W-1:DIVN_W-Q_W];
    assign trial    = {rem_reg, low_reg[Q_W-1]};
    assign diff     = trial - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (start) begin
            if (top_part >= Q_W'(divisor)) begin
                // quotient would not fit
                ovf_next  = 1'b1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                ovf_next  = 1'b0;
                done_next = 1'b0;
                busy_next = 1'b1;
                cnt_next  = CNT_W'(Q_W);
                rem_next  = top_part[DT_W-1:0];
                low_next  = dividend[Q_W-1:0];
            end
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[DT_W-1:0];
                quo_next = {quo_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DT_W-1:0];
                quo_next = {quo_reg[Q_W-2:0], 1'b0};
            end
            low_next = {low_reg[Q_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign quotient  = quo_reg;

endmodule

[hw/rtl/jve_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jve_chk - port level checks of the joint velocity estimator
// watches the handshakes and result fields seen at the top level
// ----------------------------------------------------------------------------
module jve_chk
    import jve_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [RATE_W-1:0] m_joint_rate_a,
    input logic signed [TQ_W-1:0]   m_joint_torque_a,
    input logic signed [TQ_W-1:0]   m_joint_torque_b,
    input logic signed [TQ_W-1:0]   m_joint_torque_c
);

    // reset leaves no result and an idle input side
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result pending or input blocked after reset");

    // one item in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    // a result appears only as the sequencer returns to idle
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result loaded while sequencer busy");

    // negated torque never shows the most negative code
    a_torque_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_joint_torque_a != TQ_MOST_NEG
                 && m_joint_torque_b != TQ_MOST_NEG
                 && m_joint_torque_c != TQ_MOST_NEG)
        else $error("torque negation not saturated");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_joint_rate_a))
        else $error("stalled result dropped or changed");

endmodule

bind joint_velocity_ewma_estimator jve_chk u_jve_chk (.*);
